>>> src/cpbn_pkg.sv
// ----------------------------------------------------------------------------
// cpbn_pkg
// Shared types and constants for the clipped pixel blend and noise unit.
// ----------------------------------------------------------------------------
package cpbn_pkg;

	localparam int COORD_BITS_DEF = 16;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PAINT_COLOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

	localparam logic [31:0] PAINT_COLOR_RST = 32'd0;
	localparam logic [7:0] ALPHA_LEVEL_RST = 8'd255;
	localparam logic [31:0] NOISE_SEED_RST = 32'd0;
	localparam logic [12:0] FRAME_WIDTH_RST = 13'd320;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd240;

	localparam logic [31:0] COORD_MUL_X = 32'd73856093;
	localparam logic [31:0] COORD_MUL_Y = 32'd19349663;
	localparam logic [31:0] MIX_MUL_A = 32'h7FEB352D;
	localparam logic [31:0] MIX_MUL_B = 32'h846CA68B;
	localparam logic [23:0] COLOR_MASK = 24'h000000;
	localparam logic [7:0] NOISE_LEVEL_BASE = 8'd40;
	localparam logic [7:0] LEVEL_OPAQUE = 8'd255;
	localparam logic [7:0] LEVEL_NONE = 8'd0;

	typedef enum logic [2:0] {
		OP_BLEND = 3'd0,
		OP_NOISE = 3'd1,
		OP_KEYED = 3'd2,
		OP_OPAQUE = 3'd3,
		OP_TINT = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		RS_DEST = 3'd0,
		RS_SRC = 3'd1,
		RS_BASE = 3'd2,
		RS_PAINT = 3'd3,
		RS_MIX = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic load_in;
		logic coord;
		logic mix1;
		logic mix2;
		logic blend;
		logic fin;
	} cpbn_cmd_t;

	typedef struct packed {
		logic noise;
	} cpbn_status_t;

endpackage

>>> src/clipped_pixel_blend_noise_unit.sv
// ----------------------------------------------------------------------------
// clipped_pixel_blend_noise_unit
// Per-pixel raster unit: rectangle blend, hashed noise, keyed and opaque
// sprite copy and tint blit, with clipping to the configured frame.
//
// Channel  Handshake            Payload
// in       in_valid/in_ready    opcode, pos_x, pos_y, dest_pixel, src_pixel,
//                               first_of_rect
// out      out_valid/out_ready  write_enable, pixel_out
// cfg      cfg_we               cfg_index, cfg_data
//
// A noise pixel passes through the coordinate multiply and then the two
// dependent hash multiplies before the blend step; every other pixel goes
// from the coordinate multiply straight to the blend. One pixel is worked on at a time.
// The result waits in an output register, so the next pixel is taken while
// it is held; a stalled output blocks only the final step of the next pixel.
// Reset loads the register defaults and clears the hash state.
// ----------------------------------------------------------------------------
module clipped_pixel_blend_noise_unit #(
	parameter int COORD_BITS = cpbn_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cpbn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpbn_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   opcode,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [31:0]                  dest_pixel,
	input  logic [31:0]                  src_pixel,
	input  logic                         first_of_rect,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         write_enable,
	output logic [31:0]                  pixel_out
);
	import cpbn_pkg::*;

	logic [31:0] paint_color_q;
	logic [7:0] alpha_level_q;
	logic [31:0] noise_seed_q;
	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	cpbn_cmd_t cmd;
	cpbn_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paint_color_q <= PAINT_COLOR_RST;
			alpha_level_q <= ALPHA_LEVEL_RST;
			noise_seed_q <= NOISE_SEED_RST;
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAINT_COLOR: paint_color_q <= cfg_data;
				REG_ALPHA_LEVEL: alpha_level_q <= cfg_data[7:0];
				REG_NOISE_SEED: noise_seed_q <= cfg_data;
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[12:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	cpbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cpbn_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.opcode        (opcode),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.dest_pixel    (dest_pixel),
		.src_pixel     (src_pixel),
		.first_of_rect (first_of_rect),
		.paint_color   (paint_color_q),
		.alpha_level   (alpha_level_q),
		.noise_seed    (noise_seed_q),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.write_enable  (write_enable),
		.pixel_out     (pixel_out)
	);

endmodule

>>> src/cpbn_ctrl.sv
// ----------------------------------------------------------------------------
// cpbn_ctrl
// Sequencer for one pixel at a time and the output valid flag.
// ----------------------------------------------------------------------------
module cpbn_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  cpbn_pkg::cpbn_status_t status,
	output cpbn_pkg::cpbn_cmd_t    cmd
);
	import cpbn_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_COORD = 6'b000010,
		ST_MIX1 = 6'b000100,
		ST_MIX2 = 6'b001000,
		ST_BLEND = 6'b010000,
		ST_FIN = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_COORD;
				end
			end
			ST_COORD: begin
				cmd.coord = 1'b1;
				state_d = status.noise ? ST_MIX1 : ST_BLEND;
			end
			ST_MIX1: begin
				cmd.mix1 = 1'b1;
				state_d = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.mix2 = 1'b1;
				state_d = ST_BLEND;
			end
			ST_BLEND: begin
				cmd.blend = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/cpbn_datapath.sv
// ----------------------------------------------------------------------------
// cpbn_datapath
// Input capture, noise hash, clipping, channel blend and output register.
// ----------------------------------------------------------------------------
module cpbn_datapath #(
	parameter int COORD_BITS = cpbn_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cpbn_pkg::cpbn_cmd_t     cmd,
	output cpbn_pkg::cpbn_status_t  status,
	input  logic [2:0]              opcode,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [31:0]             dest_pixel,
	input  logic [31:0]             src_pixel,
	input  logic                    first_of_rect,
	input  logic [31:0]             paint_color,
	input  logic [7:0]              alpha_level,
	input  logic [31:0]             noise_seed,
	input  logic [12:0]             frame_width,
	input  logic [12:0]             frame_height,
	output logic                    write_enable,
	output logic [31:0]             pixel_out
);
	import cpbn_pkg::*;

	logic [2:0] op_q;
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [31:0] dest_q, src_q;
	logic first_q;
	logic [31:0] px_q, py_q, m1_q, m2_q, hash_q;
	logic [31:0] base_q;
	res_sel_t sel_q;
	logic [2:0] neg_q;
	logic [15:0] prod_q [3];
	logic we_out_q;
	logic [31:0] pix_out_q;

	logic [31:0] v_sum, v_a, v_b, h_val;
	logic in_frame, keyed, we_d, noise_hit;
	logic [7:0] lvl;
	logic [31:0] base_d;
	res_sel_t sel_d;
	logic [7:0] d_ch [3];
	logic [7:0] s_ch [3];
	logic [2:0] neg_d;
	logic [7:0] mag [3];
	logic [16:0] qt [3];
	logic [7:0] c_ch [3];
	logic [31:0] pix_d;

	assign status.noise = (op_q == OP_NOISE);

	assign v_sum = (first_q ? noise_seed : hash_q) + px_q + py_q;
	assign v_a = v_sum ^ (v_sum >> 16);
	assign v_b = m1_q ^ (m1_q >> 15);
	assign h_val = m2_q ^ (m2_q >> 16);

	always_comb begin
		in_frame = !x_q[COORD_BITS-1] && !y_q[COORD_BITS-1]
			&& (33'($unsigned(x_q)) < 33'(frame_width))
			&& (33'($unsigned(y_q)) < 33'(frame_height));
		keyed = (src_q[23:0] == COLOR_MASK);
		noise_hit = (h_val[7:0] < alpha_level);
		lvl = alpha_level;
		base_d = dest_q;
		we_d = 1'b0;
		case (op_q)
			OP_BLEND: begin
				we_d = in_frame;
			end
			OP_NOISE: begin
				we_d = in_frame && noise_hit;
				lvl = NOISE_LEVEL_BASE + {2'b00, h_val[13:8]};
			end
			OP_KEYED: begin
				we_d = in_frame && !keyed;
			end
			OP_OPAQUE: begin
				we_d = in_frame;
			end
			OP_TINT: begin
				we_d = in_frame && !keyed;
				base_d = src_q;
			end
			default: begin
				we_d = 1'b0;
			end
		endcase
		if (!we_d) begin
			sel_d = RS_DEST;
		end else if (op_q inside {OP_KEYED, OP_OPAQUE}) begin
			sel_d = RS_SRC;
		end else if (lvl == LEVEL_NONE) begin
			sel_d = RS_BASE;
		end else if (lvl == LEVEL_OPAQUE) begin
			sel_d = RS_PAINT;
		end else begin
			sel_d = RS_MIX;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_ch[k] = base_d[8*k +: 8];
			s_ch[k] = paint_color[8*k +: 8];
			neg_d[k] = s_ch[k] < d_ch[k];
			mag[k] = neg_d[k] ? (d_ch[k] - s_ch[k]) : (s_ch[k] - d_ch[k]);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qt[k] = 17'(prod_q[k]) + 17'd1 + 17'(prod_q[k][15:8]);
			c_ch[k] = neg_q[k] ? (base_q[8*k +: 8] - qt[k][15:8])
				: (base_q[8*k +: 8] + qt[k][15:8]);
		end
		case (sel_q)
			RS_DEST: pix_d = dest_q;
			RS_SRC: pix_d = src_q;
			RS_BASE: pix_d = base_q;
			RS_PAINT: pix_d = paint_color;
			RS_MIX: pix_d = {8'h00, c_ch[2], c_ch[1], c_ch[0]};
			default: pix_d = dest_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 32'd0;
		end else if (cmd.blend && status.noise) begin
			hash_q <= h_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode;
			x_q <= pos_x;
			y_q <= pos_y;
			dest_q <= dest_pixel;
			src_q <= src_pixel;
			first_q <= first_of_rect;
		end
		if (cmd.coord) begin
			px_q <= 32'(x_q) * COORD_MUL_X;
			py_q <= 32'(y_q) * COORD_MUL_Y;
		end
		if (cmd.mix1) begin
			m1_q <= v_a * MIX_MUL_A;
		end
		if (cmd.mix2) begin
			m2_q <= v_b * MIX_MUL_B;
		end
		if (cmd.blend) begin
			base_q <= base_d;
			sel_q <= sel_d;
			neg_q <= neg_d;
			for (int k = 0; k < 3; k++) begin
				prod_q[k] <= mag[k] * lvl;
			end
		end
		if (cmd.fin) begin
			we_out_q <= (sel_q != RS_DEST);
			pix_out_q <= pix_d;
		end
	end

	assign write_enable = we_out_q;
	assign pixel_out = pix_out_q;

endmodule
